// ----- sv/three_stack_shared_memory_unit_assert.svh -----
// Assertion macros for the three-stack unit.
`ifndef THREE_STACK_SHARED_MEMORY_UNIT_ASSERT_SVH
`define THREE_STACK_SHARED_MEMORY_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSSM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tssm assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TSSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tssm assertion failed");

`endif

// ----- sv/tssm_pkg.sv -----
// Package: constants, types and helpers for the three-stack unit.
`timescale 1ns / 1ps
package tssm_pkg;
	localparam int STACK_DEPTH = 256;
	localparam int DATA_WIDTH  = 32;
	localparam int NUM_STACKS  = 3;

	localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
	localparam int SIZE_W    = 9;
	localparam int CMP_W     = (SIZE_W > FILL_W) ? SIZE_W : FILL_W;
	localparam int SEL_W     = 2;
	localparam int VAL_W     = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [FILL_W-1:0]     fill_t;
	typedef logic [SIZE_W-1:0]     size_t;
	typedef logic [CMP_W-1:0]      cmp_t;
	typedef logic [SEL_W-1:0]      sel_t;
	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic signed [VAL_W-1:0] value_t;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_UNDERFLOW = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_LOAD
	} state_t;

	typedef struct packed {
		logic exec;
		logic load;
	} cmd_t;

	function automatic addr_t stack_base(input sel_t sel);
		return ADDR_W'(int'(sel) * STACK_DEPTH);
	endfunction

	function automatic word_t to_word(input value_t v);
		logic [63:0] t;
		t = {32'd0, v};
		return t[DATA_WIDTH-1:0];
	endfunction

	function automatic value_t from_word(input word_t w);
		logic [63:0] t;
		t = 64'(w);
		return value_t'(t[VAL_W-1:0]);
	endfunction
endpackage

// ----- sv/tssm_if.sv -----
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface tssm_req_if;
	logic              valid;
	logic              ready;
	tssm_pkg::action_t action;
	tssm_pkg::sel_t    stack_sel;
	tssm_pkg::value_t  push_value;

	modport source(output valid, action, stack_sel, push_value, input ready);
	modport sink(input valid, action, stack_sel, push_value, output ready);
endinterface

interface tssm_rsp_if;
	logic              valid;
	logic              ready;
	tssm_pkg::value_t  pop_value;
	tssm_pkg::status_t status;

	modport source(output valid, pop_value, status, input ready);
	modport sink(input valid, pop_value, status, output ready);
endinterface

// ----- sv/three_stack_shared_memory_unit.sv -----
// Top level: three LIFO stacks in one shared memory.
// Each request beat is a push or a pop on stack 0..2 and yields exactly one
// response beat carrying pop_value and status (ok, invalid stack, overflow,
// underflow; pop_value is zero unless a pop succeeds). In S_IDLE the accept
// cycle checks the fill counter, updates it and issues the single memory
// access; S_LOAD then moves the registered memory read into the output
// register, and stalls there while the previous response beat is still held.
// Requests are then taken again, so no new item is accepted until the last
// one's result is loaded. The stack_size register caps each stack's height
// (values above the partition depth act as the depth, zero blocks all pushes)
// and resets to 256; write it only while the unit is idle.
`timescale 1ns / 1ps
`include "three_stack_shared_memory_unit_assert.svh"
module three_stack_shared_memory_unit (
	input  logic            clk,
	input  logic            arst_n,
	tssm_req_if.sink        req,
	tssm_rsp_if.source      rsp,
	input  logic            cfg_we,
	input  tssm_pkg::size_t cfg_wdata
);
	tssm_pkg::cmd_t cmd;

	tssm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd      (cmd)
	);

	tssm_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.action    (req.action),
		.stack_sel (req.stack_sel),
		.push_value(req.push_value),
		.pop_value (rsp.pop_value),
		.status    (rsp.status)
	);

	`TSSM_ASSERT_NEXT(a_one_item_in_flight, cmd.exec, !req.ready)
	`TSSM_ASSERT_NEXT(a_load_shows_beat, cmd.load, rsp.valid)
	`TSSM_ASSERT_NOW(a_no_exec_and_load, cmd.exec, !cmd.load)
	`TSSM_ASSERT_NOW(a_error_zero_value, rsp.valid && rsp.status != tssm_pkg::ST_OK, rsp.pop_value == '0)
endmodule

// ----- sv/tssm_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tssm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- sv/tssm_ctrl.sv -----
// Controller: sequences accept, execute and result load.
`timescale 1ns / 1ps
module tssm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output tssm_pkg::cmd_t     cmd
);
	tssm_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tssm_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			tssm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.exec = in_valid;
				if (in_valid) begin
					state_d = tssm_pkg::S_LOAD;
				end
			end
			tssm_pkg::S_LOAD: begin
				// hold until the output beat slot is free
				cmd.load = !out_valid_q || out_ready;
				if (cmd.load) begin
					state_d = tssm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tssm_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

// ----- sv/tssm_dpath.sv -----
// Datapath: fill counters, size register, stack memory and result register.
`timescale 1ns / 1ps
module tssm_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  tssm_pkg::cmd_t     cmd,
	input  logic               cfg_we,
	input  tssm_pkg::size_t    cfg_wdata,
	input  tssm_pkg::action_t  action,
	input  tssm_pkg::sel_t     stack_sel,
	input  tssm_pkg::value_t   push_value,
	output tssm_pkg::value_t   pop_value,
	output tssm_pkg::status_t  status
);
	tssm_pkg::fill_t   fill_q [tssm_pkg::NUM_STACKS];
	tssm_pkg::size_t   size_q;
	tssm_pkg::status_t status_s1;
	logic              pop_ok_s1;
	tssm_pkg::addr_t   addr_s1;
	tssm_pkg::value_t  pop_value_q;
	tssm_pkg::status_t status_q;

	tssm_pkg::fill_t   fill_cur;
	tssm_pkg::fill_t   fill_nxt;
	tssm_pkg::cmp_t    eff_size;
	tssm_pkg::status_t status_d;
	logic              sel_ok;
	logic              push_ok;
	logic              pop_ok;
	logic              ram_we;
	tssm_pkg::addr_t   op_addr;
	tssm_pkg::addr_t   ram_addr;
	tssm_pkg::word_t   ram_rdata;

	always_comb begin
		fill_cur = '0;
		for (int i = 0; i < tssm_pkg::NUM_STACKS; i++) begin
			if (stack_sel == tssm_pkg::SEL_W'(i)) begin
				fill_cur = fill_q[i];
			end
		end
		sel_ok   = stack_sel < tssm_pkg::SEL_W'(tssm_pkg::NUM_STACKS);
		eff_size = (tssm_pkg::CMP_W'(size_q) > tssm_pkg::CMP_W'(tssm_pkg::STACK_DEPTH))
			? tssm_pkg::CMP_W'(tssm_pkg::STACK_DEPTH) : tssm_pkg::CMP_W'(size_q);
		push_ok  = 1'b0;
		pop_ok   = 1'b0;
		fill_nxt = fill_cur;
		if (!sel_ok) begin
			status_d = tssm_pkg::ST_INVALID;
		end else if (action == tssm_pkg::ACT_PUSH) begin
			if (tssm_pkg::CMP_W'(fill_cur) >= eff_size) begin
				status_d = tssm_pkg::ST_OVERFLOW;
			end else begin
				status_d = tssm_pkg::ST_OK;
				push_ok  = 1'b1;
				fill_nxt = fill_cur + tssm_pkg::FILL_W'(1);
			end
		end else begin
			if (fill_cur == '0) begin
				status_d = tssm_pkg::ST_UNDERFLOW;
			end else begin
				status_d = tssm_pkg::ST_OK;
				pop_ok   = 1'b1;
				fill_nxt = fill_cur - tssm_pkg::FILL_W'(1);
			end
		end
		ram_we   = cmd.exec && push_ok;
		op_addr  = tssm_pkg::stack_base(stack_sel)
			+ tssm_pkg::ADDR_W'(push_ok ? fill_cur : fill_nxt);
		// hold the read address so the read word stays put while the result waits
		ram_addr = cmd.exec ? op_addr : addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= tssm_pkg::SIZE_RESET;
			for (int i = 0; i < tssm_pkg::NUM_STACKS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			if (cmd.exec && (push_ok || pop_ok)) begin
				for (int i = 0; i < tssm_pkg::NUM_STACKS; i++) begin
					if (stack_sel == tssm_pkg::SEL_W'(i)) begin
						fill_q[i] <= fill_nxt;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_s1 <= status_d;
			pop_ok_s1 <= pop_ok;
			addr_s1   <= op_addr;
		end
		if (cmd.load) begin
			pop_value_q <= pop_ok_s1 ? tssm_pkg::from_word(ram_rdata) : '0;
			status_q    <= status_s1;
		end
	end

	tssm_ram #(
		.WIDTH(tssm_pkg::DATA_WIDTH),
		.DEPTH(tssm_pkg::MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(tssm_pkg::to_word(push_value)),
		.rdata(ram_rdata)
	);

	assign pop_value = pop_value_q;
	assign status    = status_q;
endmodule
